// ----- hdl/fch_pkg.sv -----
// shared types and constants of the flow counter hash table
package fch_pkg;

    localparam int unsigned KEY_W     = 32;
    localparam int unsigned PROTO_W   = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CNT_W     = 64;
    localparam int unsigned SLOT_W    = 14;
    localparam logic [31:0] JHASH_INIT = 32'hdeadbeef + 32'd12;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_NEW  = 2'd1,
        ST_DROP = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]   source_address;
        logic [KEY_W-1:0]   destination_address;
        logic [PROTO_W-1:0] protocol_number;
        logic [LEN_W-1:0]   packet_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        update_status;
        logic [CNT_W-1:0]  flow_packets;
        logic [CNT_W-1:0]  flow_bytes;
        logic [SLOT_W-1:0] entry_slot;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   src;
        logic [KEY_W-1:0]   dst;
        logic [PROTO_W-1:0] proto;
        logic [CNT_W-1:0]   pkts;
        logic [CNT_W-1:0]   bytes;
    } entry_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
        rotl = (x << k) | (x >> (32 - k));
    endfunction

endpackage

// ----- hdl/fch_hash.sv -----
// iterative three-word key hash, bucket taken from the low hash bits
module fch_hash #(
    parameter int unsigned BW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   a_in,
    input  logic [31:0]   b_in,
    input  logic [31:0]   c_in,
    input  logic [31:0]   seed,
    output logic          done,
    output logic [BW-1:0] bucket
);
    import fch_pkg::*;

    typedef enum logic {H_IDLE, H_MIX} hstate_t;

    hstate_t      state_reg;
    logic [2:0]   cnt_reg;
    logic [31:0]  a_reg, b_reg, c_reg;
    logic [31:0]  a_next, b_next, c_next;
    logic [31:0]  init;

    assign init = seed + JHASH_INIT;

    // one mixing line per cycle
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        case (cnt_reg)
            3'd0: c_next = (c_reg ^ b_reg) - rotl(b_reg, 14);
            3'd1: a_next = (a_reg ^ c_reg) - rotl(c_reg, 11);
            3'd2: b_next = (b_reg ^ a_reg) - rotl(a_reg, 25);
            3'd3: c_next = (c_reg ^ b_reg) - rotl(b_reg, 16);
            3'd4: a_next = (a_reg ^ c_reg) - rotl(c_reg, 4);
            3'd5: b_next = (b_reg ^ a_reg) - rotl(a_reg, 14);
            3'd6: c_next = (c_reg ^ b_reg) - rotl(b_reg, 24);
            default: c_next = c_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= H_MIX;
                        cnt_reg   <= '0;
                    end
                end
                H_MIX:
                begin
                    if (cnt_reg == 3'd6)
                    begin
                        state_reg <= H_IDLE;
                        cnt_reg   <= '0;
                        done      <= 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg + 3'd1;
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == H_IDLE && start)
        begin
            a_reg <= a_in + init;
            b_reg <= b_in + init;
            c_reg <= c_in + init;
        end
        else if (state_reg == H_MIX)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    // bucket count is a power of two, so the modulo is the low bits
    assign bucket = c_reg[BW-1:0];

endmodule

// ----- hdl/fch_table.sv -----
// bucket row memory and per-row valid memory with clearing sweep
module fch_table #(
    parameter int unsigned BUCKETS = 4096,
    parameter int unsigned WAYS    = 4,
    parameter int unsigned BW      = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [BW-1:0]          rd_addr,
    input  logic                   wr_en,
    input  logic [BW-1:0]          wr_addr,
    input  fch_pkg::entry_t [WAYS-1:0] wr_row,
    input  logic [WAYS-1:0]        wr_valid,
    output fch_pkg::entry_t [WAYS-1:0] rd_row,
    output logic [WAYS-1:0]        rd_valid,
    output logic                   clear_busy
);
    import fch_pkg::*;

    entry_t [WAYS-1:0] data_mem  [BUCKETS];
    logic   [WAYS-1:0] valid_mem [BUCKETS];
    logic   [BW-1:0]   clr_reg;
    logic              busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_reg == BW'(BUCKETS - 1))
                busy_reg <= 1'b0;
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            valid_mem[clr_reg] <= '0;
        else if (wr_en)
            valid_mem[wr_addr] <= wr_valid;
        if (rd_en)
            rd_valid <= valid_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            data_mem[wr_addr] <= wr_row;
        if (rd_en)
            rd_row <= data_mem[rd_addr];
    end

    assign clear_busy = busy_reg;

endmodule

// ----- hdl/flow_counter_hash_table_unit.sv -----
// top level of the hashed flow statistics table
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data (fch_pkg::in_item_t)
// out     | output    | out_valid / out_ready| out_data (fch_pkg::out_item_t)
// cfg     | input     | apb psel/penable     | hash_seed at address 0
//
// an item goes from accept through 7 hash mixing steps, one bucket row read and
// a compare and write-back before the next accept; a full output stalls the write-back
// BUCKETS must be a power of two; the bucket is the low hash bits
// after reset the valid memory is swept, one bucket a cycle, before any item is taken
// one item is in work at a time; the output register lets the next item in
// while a result waits, a finished lookup holds until the output is free
module flow_counter_hash_table_unit #(
    parameter int unsigned BUCKETS = 4096,
    parameter int unsigned WAYS    = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fch_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fch_pkg::out_item_t  out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fch_pkg::*;

    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned SW = $clog2(BUCKETS * WAYS) + 1;
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_HASH, S_LOOK} state_t;

    state_t             state_reg;
    logic [31:0]        seed_reg;
    in_item_t           item_reg;
    logic [BW-1:0]      bucket_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               hash_done;
    logic [BW-1:0]      hash_bucket;
    logic               clear_busy;
    entry_t [WAYS-1:0]  rd_row;
    logic   [WAYS-1:0]  rd_valid;
    entry_t [WAYS-1:0]  wr_row;
    logic   [WAYS-1:0]  wr_valid;
    logic               wr_en;
    logic               accept;
    logic               finish;
    out_item_t          result;

    logic               hit;
    logic               have_free;
    logic [WW-1:0]      way_sel;
    logic [SW-1:0]      slot_full;
    logic [31:0]        slot32;
    entry_t             upd;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (psel && penable && pwrite && !paddr[2])
            seed_reg <= pwdata;
    end

    fch_hash #(.BW(BW)) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .a_in   (in_data.source_address),
        .b_in   (in_data.destination_address),
        .c_in   ({24'd0, in_data.protocol_number}),
        .seed   (seed_reg),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    fch_table #(.BUCKETS(BUCKETS), .WAYS(WAYS), .BW(BW)) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (hash_done),
        .rd_addr    (hash_bucket),
        .wr_en      (wr_en),
        .wr_addr    (bucket_reg),
        .wr_row     (wr_row),
        .wr_valid   (wr_valid),
        .rd_row     (rd_row),
        .rd_valid   (rd_valid),
        .clear_busy (clear_busy)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == S_LOOK) && (!out_valid_reg || out_ready);

    // way compare, lowest hit or lowest free way
    always_comb
    begin
        hit       = 1'b0;
        have_free = 1'b0;
        way_sel   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && rd_valid[w] && rd_row[w].src == item_reg.source_address
                && rd_row[w].dst == item_reg.destination_address
                && rd_row[w].proto == item_reg.protocol_number)
            begin
                hit     = 1'b1;
                way_sel = WW'(w);
            end
        end
        if (!hit)
        begin
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (!rd_valid[w])
                begin
                    have_free = 1'b1;
                    way_sel   = WW'(w);
                end
            end
        end
    end

    always_comb
    begin
        upd       = rd_row[way_sel];
        upd.src   = item_reg.source_address;
        upd.dst   = item_reg.destination_address;
        upd.proto = item_reg.protocol_number;
        if (hit)
        begin
            upd.pkts  = rd_row[way_sel].pkts + 64'd1;
            upd.bytes = rd_row[way_sel].bytes + CNT_W'(item_reg.packet_length);
        end
        else
        begin
            upd.pkts  = 64'd1;
            upd.bytes = CNT_W'(item_reg.packet_length);
        end
        wr_row           = rd_row;
        wr_row[way_sel]  = upd;
        wr_valid         = rd_valid;
        wr_valid[way_sel] = 1'b1;
        wr_en            = finish && (hit || have_free);

        slot_full = SW'(bucket_reg) * SW'(WAYS) + SW'(way_sel);
        slot32    = 32'(slot_full);
        if (hit || have_free)
        begin
            result.update_status = hit ? ST_HIT : ST_NEW;
            result.flow_packets  = upd.pkts;
            result.flow_bytes    = upd.bytes;
            result.entry_slot    = slot32[SLOT_W-1:0];
        end
        else
        begin
            result.update_status = ST_DROP;
            result.flow_packets  = '0;
            result.flow_bytes    = '0;
            result.entry_slot    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                    if (!clear_busy)
                        state_reg <= S_IDLE;
                S_IDLE:
                    if (accept)
                        state_reg <= S_HASH;
                S_HASH:
                    if (hash_done)
                        state_reg <= S_LOOK;
                S_LOOK:
                    if (finish)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        if (hash_done)
            bucket_reg <= hash_bucket;
        if (finish)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second item taken while one is in work");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.update_status == ST_DROP |->
            out_data.flow_packets == 64'd0 && out_data.flow_bytes == 64'd0)
        else $error("dropped item carries counters");

    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.update_status == ST_NEW |-> out_data.flow_packets == 64'd1)
        else $error("new entry without packet count of one");

endmodule
